### rtl/half_duplex_tx_direction_control_assert.svh
`ifndef HALF_DUPLEX_TX_DIRECTION_CONTROL_ASSERT_SVH
`define HALF_DUPLEX_TX_DIRECTION_CONTROL_ASSERT_SVH

// clocked check, skipped while reset is high
`define HDTX_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check, also held during reset
`define HDTX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hdtx_pkg.sv
package hdtx_pkg;

   localparam int FIFO_DEPTH = 64;
   localparam int IDX_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int FREE_W     = 6;
   localparam int NEST_W     = 8;
   localparam int BYTE_W     = 8;
   localparam int FUNC_W     = 3;
   localparam int RSP_W      = 32;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [NEST_W-1:0] nest_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [FREE_W-1:0] free_type;

   typedef enum logic [FUNC_W-1:0] {
      FN_BEGIN = 3'd0,
      FN_END   = 3'd1,
      FN_WRITE = 3'd2,
      FN_UDRE  = 3'd3,
      FN_SHIFT = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNDER   = 2'd1,
      ST_NOWRITE = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic       driver_enable;
      logic       tx_valid;
      logic       use_ram;
      byte_type   tx_byte;
      status_type status;
      free_type   free_space;
      nest_type   nest_depth;
      logic       release_pending;
   } desc_type;

   function automatic idx_type next_index(idx_type i);
      return (i == IDX_W'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic free_type free_of(idx_type head, idx_type tail);
      logic [CNT_W-1:0] queued;
      if (head >= tail) begin
         queued = CNT_W'(head) - CNT_W'(tail);
      end else begin
         queued = CNT_W'(head) + CNT_W'(FIFO_DEPTH) - CNT_W'(tail);
      end
      return FREE_W'(CNT_W'(FIFO_DEPTH - 1) - queued);
   endfunction

endpackage

### rtl/hdtx_ram.sv
module hdtx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/hdtx_front.sv
module hdtx_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [hdtx_pkg::FUNC_W-1:0] req_func,
   input  hdtx_pkg::byte_type      req_byte,
   output logic                    s1_valid,
   output hdtx_pkg::desc_type      s1_desc,
   input  logic                    s1_ready,
   output logic                    ram_wr_en,
   output hdtx_pkg::idx_type       ram_wr_addr,
   output hdtx_pkg::byte_type      ram_wr_data,
   output logic                    ram_rd_en,
   output hdtx_pkg::idx_type       ram_rd_addr
);
   import hdtx_pkg::*;

   `include "half_duplex_tx_direction_control_assert.svh"

   idx_type  head_ff, head_in, tail_ff, tail_in;
   nest_type nest_ff, nest_in;
   logic     feeding_ff, feeding_in;
   logic     shift_done_ff, shift_done_in;
   logic     drive_on_ff, drive_on_in;
   logic     release_wait_ff, release_wait_in;
   logic     s1_valid_ff, s1_valid_in;
   desc_type s1_desc_ff, s1_desc_in;
   logic     accept;
   logic     valid;
   logic     use_ram;
   byte_type tx_byte;
   status_type status;

   assign req_tready = !s1_valid_ff || s1_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      nest_in         = nest_ff;
      feeding_in      = feeding_ff;
      shift_done_in   = shift_done_ff;
      drive_on_in     = drive_on_ff;
      release_wait_in = release_wait_ff;
      status          = ST_OK;
      valid           = 1'b0;
      use_ram         = 1'b0;
      tx_byte         = '0;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;

      case (func_type'(req_func))
         FN_BEGIN: begin
            if (nest_ff == '0) begin
               nest_in         = NEST_W'(1);
               drive_on_in     = 1'b1;
               release_wait_in = 1'b0;
            end else if (nest_ff != '1) begin
               nest_in = nest_ff + 1'b1;
            end
         end
         FN_END: begin
            if (nest_ff == '0) begin
               status = ST_UNDER;
            end else begin
               nest_in = nest_ff - 1'b1;
               if (nest_ff == NEST_W'(1)) begin
                  release_wait_in = 1'b1;
               end
            end
         end
         FN_WRITE: begin
            if (nest_ff == '0) begin
               status = ST_NOWRITE;
            end else if (next_index(head_ff) == tail_ff) begin
               status = ST_FULL;
            end else if (feeding_ff) begin
               ram_wr_en = accept;
               head_in   = next_index(head_ff);
            end else begin
               // uart idle and queue empty: byte goes straight out
               head_in       = next_index(head_ff);
               tail_in       = next_index(tail_ff);
               valid         = 1'b1;
               tx_byte       = req_byte;
               shift_done_in = 1'b0;
               feeding_in    = 1'b1;
            end
         end
         FN_UDRE: begin
            if (feeding_ff) begin
               if (head_ff != tail_ff) begin
                  ram_rd_en     = accept;
                  use_ram       = 1'b1;
                  valid         = 1'b1;
                  tail_in       = next_index(tail_ff);
                  shift_done_in = 1'b0;
               end else begin
                  feeding_in = 1'b0;
               end
            end
         end
         FN_SHIFT: begin
            shift_done_in = 1'b1;
         end
         default: begin
         end
      endcase

      if (release_wait_in && head_in == tail_in && !feeding_in && shift_done_in) begin
         drive_on_in     = 1'b0;
         release_wait_in = 1'b0;
      end

      s1_desc_in.driver_enable   = drive_on_in;
      s1_desc_in.tx_valid        = valid;
      s1_desc_in.use_ram         = use_ram;
      s1_desc_in.tx_byte         = tx_byte;
      s1_desc_in.status          = status;
      s1_desc_in.free_space      = free_of(head_in, tail_in);
      s1_desc_in.nest_depth      = nest_in;
      s1_desc_in.release_pending = release_wait_in;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign ram_wr_addr = head_ff;
   assign ram_wr_data = req_byte;
   assign ram_rd_addr = tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         tail_ff         <= '0;
         nest_ff         <= '0;
         feeding_ff      <= 1'b0;
         shift_done_ff   <= 1'b1;
         drive_on_ff     <= 1'b0;
         release_wait_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            head_ff         <= head_in;
            tail_ff         <= tail_in;
            nest_ff         <= nest_in;
            feeding_ff      <= feeding_in;
            shift_done_ff   <= shift_done_in;
            drive_on_ff     <= drive_on_in;
            release_wait_ff <= release_wait_in;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_desc_ff <= s1_desc_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_desc  = s1_desc_ff;

   `HDTX_ASSERT(idle_uart_empty_queue, clock, reset, !feeding_ff |-> head_ff == tail_ff,
      "uart idle with bytes still queued")
   `HDTX_ASSERT(nested_implies_driver, clock, reset, nest_ff != '0 |-> drive_on_ff,
      "write mode without the driver on")
   `HDTX_ASSERT(pending_release_state, clock, reset,
      release_wait_ff |-> (drive_on_ff && nest_ff == '0),
      "release pending outside a driven idle count")
   `HDTX_ASSERT_ALWAYS(stage_hold, clock,
      (!reset && $past(!reset) && $past(s1_valid_ff && !s1_ready)) |-> s1_valid_ff,
      "staged request lost while stalled")

endmodule

### rtl/hdtx_back.sv
module hdtx_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         s1_valid,
   input  hdtx_pkg::desc_type           s1_desc,
   output logic                         s1_ready,
   input  hdtx_pkg::byte_type           ram_rd_data,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [hdtx_pkg::RSP_W-1:0]   rsp_tdata
);
   import hdtx_pkg::*;

   desc_type   entry_ff [2];
   desc_type   merged;
   desc_type   head;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign s1_ready = count_ff != 2'd2;
   assign push     = s1_valid && s1_ready;
   assign pop      = rsp_tvalid && rsp_tready;

   always_comb begin
      merged = s1_desc;
      if (s1_desc.use_ram) begin
         merged.tx_byte = ram_rd_data;
      end
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= merged;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = {4'b0000,
                        head.release_pending,
                        head.nest_depth,
                        head.free_space,
                        head.status,
                        head.tx_byte,
                        head.tx_valid,
                        !head.driver_enable,
                        head.driver_enable};

endmodule

### rtl/half_duplex_tx_direction_control.sv
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready   tuser: func; tdata: data_byte
// rsp       out   rsp_tvalid/rsp_tready   tdata: direction, tx byte, status, fifo, nest
//
// one request per cycle while the response side keeps up; each request yields one response
// the fifo byte for a data register empty request is read from the ram port as the front stage loads
// a two-entry response queue lets requests keep flowing while a response waits
// reset clears all control state; fifo contents are undefined until written
// a stalled response side stops requests only once the queue and the stage are full
module half_duplex_tx_direction_control (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic [2:0]  req_tuser,  // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [0] driver_enable, [1] receiver_enable, [2] tx_valid,
                                   // [10:3] tx_byte, [12:11] status, [18:13] free_space,
                                   // [26:19] nest_depth, [27] release_pending, [31:28] zero
);
   import hdtx_pkg::*;

   logic     s1_valid, s1_ready;
   desc_type s1_desc;
   logic     ram_wr_en, ram_rd_en;
   idx_type  ram_wr_addr, ram_rd_addr;
   byte_type ram_wr_data, ram_rd_data;

   hdtx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_func    (req_tuser),
      .req_byte    (req_tdata),
      .s1_valid    (s1_valid),
      .s1_desc     (s1_desc),
      .s1_ready    (s1_ready),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   hdtx_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hdtx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1_desc     (s1_desc),
      .s1_ready    (s1_ready),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

### tb/tb_half_duplex_tx_direction_control.sv
module tb_half_duplex_tx_direction_control;
   import hdtx_pkg::*;

   typedef struct {
      logic       drv_en;
      logic       rcv_en;
      logic       txv;
      byte_type   txb;
      status_type st;
      free_type   free;
      nest_type   nest;
      logic       rel;
      logic [3:0] pad;
   } line_state_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;  // [7:0] data_byte
   logic [2:0]  req_tuser  = '0;  // [2:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [0] driver_enable, [1] receiver_enable, [2] tx_valid,
                                  // [10:3] tx_byte, [12:11] status, [18:13] free_space,
                                  // [26:19] nest_depth, [27] release_pending, [31:28] zero

   // shadow of the transmit side
   byte_type ring [FIFO_DEPTH];
   int       head_pos;
   int       tail_pos;
   nest_type nest_level;
   logic     feeding;
   logic     shifted;
   logic     drive;
   logic     releasing;

   line_state_type awaited_rsp [$];
   int   errors     = 0;
   int   items_sent = 0;
   int   burst_left = 0;
   int   gap_max    = 4;
   logic gaps_on    = 1'b1;
   logic [31:0] ready_pattern = '0;
   int   pattern_left = 0;

   always #5 clock = ~clock;

   half_duplex_tx_direction_control u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic line_state_type split_rsp(logic [31:0] w);
      line_state_type s;
      s.drv_en = w[0];
      s.rcv_en = w[1];
      s.txv    = w[2];
      s.txb    = w[10:3];
      s.st     = status_type'(w[12:11]);
      s.free   = w[18:13];
      s.nest   = w[26:19];
      s.rel    = w[27];
      s.pad    = w[31:28];
      return s;
   endfunction

   function automatic byte_type rnd_byte();
      return byte_type'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_rsp(line_state_type got, line_state_type want);
      if (got.drv_en !== want.drv_en)
         report_mismatch($sformatf("driver_enable %b want %b", got.drv_en, want.drv_en));
      if (got.rcv_en !== want.rcv_en)
         report_mismatch($sformatf("receiver_enable %b want %b", got.rcv_en, want.rcv_en));
      if (got.txv !== want.txv)
         report_mismatch($sformatf("tx_valid %b want %b", got.txv, want.txv));
      if (got.txb !== want.txb)
         report_mismatch($sformatf("tx_byte %h want %h", got.txb, want.txb));
      if (got.st !== want.st)
         report_mismatch($sformatf("status %0d want %0d", got.st, want.st));
      if (got.free !== want.free)
         report_mismatch($sformatf("free_space %0d want %0d", got.free, want.free));
      if (got.nest !== want.nest)
         report_mismatch($sformatf("nest_depth %0d want %0d", got.nest, want.nest));
      if (got.rel !== want.rel)
         report_mismatch($sformatf("release_pending %b want %b", got.rel, want.rel));
      if (got.pad !== want.pad)
         report_mismatch($sformatf("padding %b want %b", got.pad, want.pad));
   endtask

   task automatic clear_shadow();
      head_pos   = 0;
      tail_pos   = 0;
      nest_level = '0;
      feeding    = 1'b0;
      shifted    = 1'b1;
      drive      = 1'b0;
      releasing  = 1'b0;
   endtask

   // next queued byte to the uart, or stop feeding when empty
   task automatic feed_uart(output logic v, output byte_type b);
      v = 1'b0;
      b = '0;
      if (head_pos != tail_pos) begin
         b        = ring[idx_type'(tail_pos)];
         tail_pos = (tail_pos + 1) % FIFO_DEPTH;
         shifted  = 1'b0;
         feeding  = 1'b1;
         v        = 1'b1;
      end else begin
         feeding = 1'b0;
      end
   endtask

   task automatic direction_step(input logic [2:0] f, input byte_type d,
                                 output line_state_type e);
      logic       v;
      byte_type   b;
      status_type st;
      int         queued;
      v  = 1'b0;
      b  = '0;
      st = ST_OK;
      case (f)
         FN_BEGIN: begin
            if (nest_level == 8'd0) begin
               nest_level = 8'd1;
               drive      = 1'b1;
               releasing  = 1'b0;
            end else if (nest_level != 8'hFF) begin
               nest_level++;
            end
         end
         FN_END: begin
            if (nest_level == 8'd0) begin
               st = ST_UNDER;
            end else begin
               nest_level--;
               if (nest_level == 8'd0) releasing = 1'b1;
            end
         end
         FN_WRITE: begin
            if (nest_level == 8'd0) begin
               st = ST_NOWRITE;
            end else if ((head_pos + 1) % FIFO_DEPTH == tail_pos) begin
               st = ST_FULL;
            end else begin
               ring[idx_type'(head_pos)] = d;
               head_pos = (head_pos + 1) % FIFO_DEPTH;
               if (!feeding) feed_uart(v, b);
            end
         end
         FN_UDRE: begin
            if (feeding) feed_uart(v, b);
         end
         FN_SHIFT: begin
            shifted = 1'b1;
         end
         default: ;
      endcase
      if (releasing && head_pos == tail_pos && !feeding && shifted) begin
         drive     = 1'b0;
         releasing = 1'b0;
      end
      queued   = (head_pos + FIFO_DEPTH - tail_pos) % FIFO_DEPTH;
      e.drv_en = drive;
      e.rcv_en = ~drive;
      e.txv    = v;
      e.txb    = v ? b : '0;
      e.st     = st;
      e.free   = free_type'(FIFO_DEPTH - 1 - queued);
      e.nest   = nest_level;
      e.rel    = releasing;
      e.pad    = '0;
   endtask

   // entered and left at a falling edge
   task automatic send_request(input logic [2:0] f, input byte_type d);
      line_state_type e;
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= d;
      do @(posedge clock); while (req_tready !== 1'b1);
      direction_step(f, d, e);
      awaited_rsp.push_back(e);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic drain_uart();
      while (feeding || head_pos != tail_pos) send_request(FN_UDRE, rnd_byte());
      send_request(FN_SHIFT, rnd_byte());
   endtask

   task automatic test_directed();
      gaps_on = 1'b0;
      send_request(FN_END, 8'h00);
      send_request(FN_WRITE, 8'hFF);
      send_request(FN_UDRE, 8'h00);
      send_request(FN_SHIFT, 8'hFF);
      send_request(3'd5, 8'hAA);
      send_request(3'd6, 8'h55);
      send_request(3'd7, 8'hFF);
      send_request(FN_BEGIN, 8'h00);
      send_request(FN_WRITE, 8'h00);
      send_request(FN_WRITE, 8'hFF);
      send_request(FN_WRITE, 8'h5A);
      send_request(FN_UDRE, 8'h00);
      send_request(FN_BEGIN, 8'hFF);
      send_request(FN_END, 8'h00);
      send_request(FN_END, 8'h00);
      // begin again while the release waits for the drain
      send_request(FN_BEGIN, 8'h00);
      send_request(FN_END, 8'h00);
      send_request(FN_UDRE, 8'hFF);
      send_request(FN_UDRE, 8'h00);
      send_request(FN_SHIFT, 8'h00);
      send_request(FN_END, 8'h00);
      wait_for_responses();
   endtask

   task automatic test_fifo_fill();
      gaps_on = 1'b1;
      gap_max = 3;
      send_request(FN_BEGIN, rnd_byte());
      repeat (FIFO_DEPTH + 3) send_request(FN_WRITE, rnd_byte());
      drain_uart();
      send_request(FN_END, rnd_byte());
   endtask

   task automatic test_nest_saturation();
      gaps_on = 1'b0;
      repeat (257) send_request(FN_BEGIN, rnd_byte());
      send_request(FN_WRITE, rnd_byte());
      repeat (258) send_request(FN_END, rnd_byte());
      drain_uart();
   endtask

   task automatic run_session();
      int r;
      repeat ($urandom_range(1, 3)) send_request(FN_BEGIN, rnd_byte());
      repeat ($urandom_range(0, 40)) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            send_request(FN_WRITE, rnd_byte());
         else if (r < 75)
            send_request(FN_UDRE, rnd_byte());
         else if (r < 83)
            send_request(FN_SHIFT, rnd_byte());
         else if (r < 89)
            send_request(FN_BEGIN, rnd_byte());
         else if (r < 94 && nest_level > 1)
            send_request(FN_END, rnd_byte());
         else
            send_request(3'($urandom_range(0, 7)), rnd_byte());
      end
      while (nest_level != 0) send_request(FN_END, rnd_byte());
      if ($urandom_range(0, 4) == 0) begin
         send_request(FN_BEGIN, rnd_byte());
         send_request(FN_WRITE, rnd_byte());
         send_request(FN_END, rnd_byte());
      end
      while (feeding || head_pos != tail_pos) begin
         r = $urandom_range(0, 99);
         if (r < 85)
            send_request(FN_UDRE, rnd_byte());
         else if (r < 92)
            send_request(FN_WRITE, rnd_byte());
         else
            send_request(FN_SHIFT, rnd_byte());
      end
      // sometimes leave the release waiting for the next session
      if ($urandom_range(0, 5) != 0) send_request(FN_SHIFT, rnd_byte());
   endtask

   task automatic test_random_sessions();
      while (items_sent < 2000) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         gap_max = $urandom_range(1, 6);
         run_session();
         if ($urandom_range(0, 7) == 0) wait_for_responses();
      end
   endtask

   // receiver stall pattern, sometimes always ready
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         ready_pattern = $urandom;
         if ($urandom_range(0, 3) == 0) ready_pattern = '1;
         ready_pattern = ready_pattern | 32'h1111_1111;
         pattern_left  = 32;
      end
      rsp_tready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
      pattern_left--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (awaited_rsp.size() == 0)
            report_mismatch($sformatf("response %h with nothing expected", rsp_tdata));
         else
            check_rsp(split_rsp(rsp_tdata), awaited_rsp.pop_front());
      end
   end

   initial begin
      clear_shadow();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_fifo_fill();
      test_nest_saturation();
      test_random_sessions();
      wait_for_responses();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
